@@ design/vortex_ring_induced_velocity_defines.svh @@
// assertion macros shared by the vortex ring velocity block
`ifndef VORTEX_RING_INDUCED_VELOCITY_DEFINES_SVH
`define VORTEX_RING_INDUCED_VELOCITY_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define VRI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define VRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/vri_pkg.sv @@
// types and constants of the vortex ring velocity block
package vri_pkg;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] corner_x;
      logic signed [31:0] corner_y;
      logic signed [31:0] corner_z;
      logic               ring_last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        is_sqrt;
      logic [63:0] operand;
      logic [41:0] divisor;
   } unit_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [43:0] result;
   } unit_rsp_type;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_DIFF  = 10'b0000000010,
      ST_MUL   = 10'b0000000100,
      ST_ADD   = 10'b0000001000,
      ST_START = 10'b0000010000,
      ST_UNIT  = 10'b0000100000,
      ST_NORM  = 10'b0001000000,
      ST_CHECK = 10'b0010000000,
      ST_SUM   = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   typedef enum logic [3:0] {
      PH_N1,
      PH_N2,
      PH_CROSS,
      PH_SQ,
      PH_U1,
      PH_U2,
      PH_K,
      PH_Q,
      PH_TERM,
      PH_SCALE
   } phase_type;

   localparam logic [31:0]  THR_RESET   = 32'd1;
   localparam logic [28:0]  INV_4PI_Q32 = 29'd341782638;
   localparam logic [127:0] ROUND_HALF  = 128'h8000_0000;
   localparam logic [46:0]  TERM_CAP    = {47{1'b1}};
   localparam logic [1:0]   CSR_THRESHOLD = 2'd0;

endpackage

@@ design/vri_iter_unit.sv @@
// shared iterative unit: restoring divide and integer square root, one step a cycle
module vri_iter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  vri_pkg::unit_req_type req,
   output vri_pkg::unit_rsp_type rsp
);
   import vri_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        sqrt_ff, sqrt_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in;
   logic [41:0] d_ff, d_in;
   logic [43:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;

   logic [43:0] rem_div, rem_sq, trial;
   logic        ge_div, ge_sq, last_step;

   always_comb begin
      rem_div   = {rem_ff[42:0], x_ff[63]};
      ge_div    = rem_div >= {2'b00, d_ff};
      rem_sq    = {rem_ff[41:0], x_ff[63:62]};
      trial     = {res_ff[41:0], 2'b01};
      ge_sq     = rem_sq >= trial;
      last_step = sqrt_ff ? (cnt_ff == 6'd31) : (cnt_ff == 6'd63);

      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;

      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         sqrt_in = req.is_sqrt;
         cnt_in  = '0;
         x_in    = req.operand;
         d_in    = req.divisor;
         rem_in  = '0;
         res_in  = '0;
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            rem_in = ge_sq ? (rem_sq - trial) : rem_sq;
            res_in = {res_ff[62:0], ge_sq};
            x_in   = {x_ff[61:0], 2'b00};
         end else begin
            rem_in = ge_div ? (rem_div - {2'b00, d_ff}) : rem_div;
            res_in = {res_ff[62:0], ge_div};
            x_in   = {x_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = res_ff[43:0];

endmodule

@@ design/vortex_ring_induced_velocity.sv @@
// top level: vortex ring induced velocity, sequenced over a shared multiplier and divide unit
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_stall   point, corner, ring_last
//   rsp_      out         rsp_valid/rsp_stall   vel_x, vel_y, vel_z
//   csr_      in/out      apb psel/penable      zero_threshold at byte 0
//
// the work of a segment is mostly the nine 64-step divides and two 32-step roots in the
// shared unit; a non-final corner costs one segment (the first corner of a ring none), a
// final corner two segments (one if it is also the first) followed by scaling.
// reset is synchronous; the threshold comes back as 1 and no ring is open.
// req_stall is high while an item is worked on; a waiting result does not block req_.
`include "vortex_ring_induced_velocity_defines.svh"
module vortex_ring_induced_velocity (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vri_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vri_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [1:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import vri_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      return v[31:0];
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [1:0] next3(input logic [1:0] i);
      case (i)
         2'd0:    return 2'd1;
         2'd1:    return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] prev3(input logic [1:0] i);
      case (i)
         2'd0:    return 2'd2;
         2'd1:    return 2'd0;
         default: return 2'd1;
      endcase
   endfunction

   function automatic logic [2:0] last_cnt(input phase_type p);
      case (p)
         PH_CROSS: return 3'd5;
         PH_TERM:  return 3'd3;
         PH_SCALE: return 3'd1;
         default:  return 3'd2;
      endcase
   endfunction

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  idx_ff, idx_in;
   logic        in_ring_ff, in_ring_in;
   logic        close_ff, close_in;
   logic        fin_ff, fin_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] thr_ff, thr_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic signed [31:0] pt_ff[3], pt_in[3];
   logic signed [31:0] first_ff[3], first_in[3];
   logic signed [31:0] prev_ff[3], prev_in[3];
   logic signed [31:0] a_ff[3], a_in[3];
   logic signed [31:0] b_ff[3], b_in[3];
   logic signed [31:0] d0_ff[3], d0_in[3];
   logic signed [31:0] d1_ff[3], d1_in[3];
   logic signed [31:0] d2_ff[3], d2_in[3];
   logic [62:0]        cmag_ff[3], cmag_in[3];
   logic [2:0]         crneg_ff, crneg_in;
   logic signed [29:0] u1_ff[3], u1_in[3];
   logic signed [29:0] u2_ff[3], u2_in[3];
   logic signed [47:0] sum_ff[3], sum_in[3];
   logic signed [31:0] vel_ff[3], vel_in[3];
   logic [31:0]  n1_ff, n1_in;
   logic [31:0]  n2_ff, n2_in;
   logic [5:0]   sh_ff, sh_in;
   logic [41:0]  s_ff, s_in;
   logic         kneg_ff, kneg_in;
   logic [61:0]  kmag_ff, kmag_in;
   logic [43:0]  q_ff, q_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [127:0] acc_ff, acc_in;

   unit_req_type unit_req;
   unit_rsp_type unit_rsp;

   logic               req_fire, csr_write, seg_end;
   logic signed [32:0] mul_a, mul_b;
   logic [1:0]         add_sh;
   logic [127:0]       prod_ext, acc_sum;
   logic [63:0]        cdiff, cneg;
   logic [62:0]        ormag;
   logic [6:0]         twosh;
   logic [41:0]        s_shift;
   logic               s_skip;
   logic [6:0]         tshamt;
   logic [127:0]       tshift;
   logic [46:0]        tmag;
   logic signed [47:0] term;
   logic signed [48:0] sum_wide;
   logic signed [47:0] sum_sat;
   logic [47:0]        smag;
   logic [95:0]        v96;
   logic [31:0]        vsat;
   logic signed [30:0] udiff;
   logic [1:0]         ci, ca, cb;
   logic [31:0]        n_new;
   logic [29:0]        uq;

   vri_iter_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   assign req_stall  = state_ff != ST_IDLE;
   assign req_fire   = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = thr_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      add_sh = 2'd0;
      ci     = cnt_ff[2:1];
      ca     = cnt_ff[0] ? prev3(ci) : next3(ci);
      cb     = cnt_ff[0] ? next3(ci) : prev3(ci);
      smag   = sum_ff[idx_ff][47] ? (~sum_ff[idx_ff] + 48'd1) : sum_ff[idx_ff];
      udiff  = {u1_ff[cnt_ff[1:0]][29], u1_ff[cnt_ff[1:0]]}
             - {u2_ff[cnt_ff[1:0]][29], u2_ff[cnt_ff[1:0]]};
      case (phase_ff)
         PH_N1: begin
            mul_a = {d1_ff[cnt_ff[1:0]][31], d1_ff[cnt_ff[1:0]]};
            mul_b = mul_a;
         end
         PH_N2: begin
            mul_a = {d2_ff[cnt_ff[1:0]][31], d2_ff[cnt_ff[1:0]]};
            mul_b = mul_a;
         end
         PH_CROSS: begin
            mul_a = {d1_ff[ca][31], d1_ff[ca]};
            mul_b = {d2_ff[cb][31], d2_ff[cb]};
         end
         PH_SQ: begin
            mul_a = {13'd0, cmag_ff[cnt_ff[1:0]][19:0]};
            mul_b = mul_a;
         end
         PH_K: begin
            mul_a = {d0_ff[cnt_ff[1:0]][31], d0_ff[cnt_ff[1:0]]};
            mul_b = {{2{udiff[30]}}, udiff};
         end
         PH_TERM: begin
            mul_a  = cnt_ff[0] ? {21'd0, q_ff[43:32]} : {1'b0, q_ff[31:0]};
            mul_b  = cnt_ff[1] ? {3'd0, kmag_ff[61:32]} : {1'b0, kmag_ff[31:0]};
            add_sh = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
         end
         PH_SCALE: begin
            mul_a  = cnt_ff[0] ? {17'd0, smag[47:32]} : {1'b0, smag[31:0]};
            mul_b  = {4'd0, INV_4PI_Q32};
            add_sh = {1'b0, cnt_ff[0]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // datapath helpers
   always_comb begin
      prod_ext = {{62{prod_ff[65]}}, prod_ff} << {add_sh, 5'b00000};
      acc_sum  = acc_ff + prod_ext;
      cdiff    = acc_ff[63:0] - prod_ff[63:0];
      cneg     = ~cdiff + 64'd1;
      ormag    = cmag_ff[0] | cmag_ff[1] | cmag_ff[2];
      twosh    = {sh_ff, 1'b0};
      s_shift  = s_ff >> (7'd48 - twosh);
      s_skip   = (s_ff == '0) || ((twosh <= 7'd48) && (s_shift < {10'd0, thr_ff}));
      tshamt   = 7'd39 + {1'b0, sh_ff};
      tshift   = acc_ff >> tshamt;
      tmag     = (|tshift[127:47]) ? TERM_CAP : tshift[46:0];
      term     = (crneg_ff[idx_ff] ^ kneg_ff) ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
      sum_wide = {sum_ff[idx_ff][47], sum_ff[idx_ff]} + {term[47], term};
      if (sum_wide[48] != sum_wide[47]) begin
         sum_sat = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         sum_sat = sum_wide[47:0];
      end
      v96 = acc_ff[127:32];
      if (sum_ff[idx_ff][47]) begin
         vsat = ((|v96[95:32]) || (v96[31] && (|v96[30:0]))) ? 32'h8000_0000 : v96[31:0];
         vsat = ~vsat + 32'd1;
      end else begin
         vsat = (|v96[95:31]) ? 32'h7FFF_FFFF : v96[31:0];
      end
      n_new = unit_rsp.result[31:0];
      uq    = {1'b0, unit_rsp.result[28:0]};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      in_ring_in   = in_ring_ff;
      close_in     = close_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      thr_in       = thr_ff;
      crneg_in     = crneg_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      sh_in        = sh_ff;
      s_in         = s_ff;
      kneg_in      = kneg_ff;
      kmag_in      = kmag_ff;
      q_in         = q_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      seg_end      = 1'b0;
      unit_req     = '0;
      for (int i = 0; i < 3; i++) begin
         pt_in[i]    = pt_ff[i];
         first_in[i] = first_ff[i];
         prev_in[i]  = prev_ff[i];
         a_in[i]     = a_ff[i];
         b_in[i]     = b_ff[i];
         d0_in[i]    = d0_ff[i];
         d1_in[i]    = d1_ff[i];
         d2_in[i]    = d2_ff[i];
         cmag_in[i]  = cmag_ff[i];
         u1_in[i]    = u1_ff[i];
         u2_in[i]    = u2_ff[i];
         sum_in[i]   = sum_ff[i];
         vel_in[i]   = vel_ff[i];
      end

      if (csr_write && csr_paddr == CSR_THRESHOLD) begin
         thr_in = csr_pwdata;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               prev_in[0] = req_data.corner_x;
               prev_in[1] = req_data.corner_y;
               prev_in[2] = req_data.corner_z;
               in_ring_in = !req_data.ring_last;
               fin_in     = req_data.ring_last;
               b_in[0]    = req_data.corner_x;
               b_in[1]    = req_data.corner_y;
               b_in[2]    = req_data.corner_z;
               if (!in_ring_ff) begin
                  pt_in[0]    = req_data.point_x;
                  pt_in[1]    = req_data.point_y;
                  pt_in[2]    = req_data.point_z;
                  first_in[0] = req_data.corner_x;
                  first_in[1] = req_data.corner_y;
                  first_in[2] = req_data.corner_z;
                  a_in[0]     = req_data.corner_x;
                  a_in[1]     = req_data.corner_y;
                  a_in[2]     = req_data.corner_z;
                  for (int i = 0; i < 3; i++) sum_in[i] = '0;
                  close_in = 1'b0;
                  if (req_data.ring_last) state_in = ST_DIFF;
               end else begin
                  for (int i = 0; i < 3; i++) a_in[i] = prev_ff[i];
                  close_in = req_data.ring_last;
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               d0_in[i] = sat32({b_ff[i][31], b_ff[i]} - {a_ff[i][31], a_ff[i]});
               d1_in[i] = sat32({a_ff[i][31], a_ff[i]} - {pt_ff[i][31], pt_ff[i]});
               d2_in[i] = sat32({b_ff[i][31], b_ff[i]} - {pt_ff[i][31], pt_ff[i]});
            end
            phase_in = PH_N1;
            cnt_in   = '0;
            acc_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (phase_ff == PH_CROSS) begin
               if (!cnt_ff[0]) begin
                  acc_in = {{62{prod_ff[65]}}, prod_ff};
               end else begin
                  crneg_in[ci] = cdiff[63];
                  cmag_in[ci]  = cdiff[63] ? cneg[62:0] : cdiff[62:0];
               end
            end else begin
               acc_in = acc_sum;
            end
            if (cnt_ff == last_cnt(phase_ff)) begin
               cnt_in = '0;
               case (phase_ff)
                  PH_N1, PH_N2: state_in = ST_START;
                  PH_CROSS: begin
                     sh_in    = '0;
                     state_in = ST_NORM;
                  end
                  PH_SQ: begin
                     s_in     = acc_sum[41:0];
                     state_in = ST_CHECK;
                  end
                  PH_K: begin
                     kneg_in  = acc_sum[63];
                     kmag_in  = acc_sum[63] ? ((~acc_sum[61:0]) + 62'd1) : acc_sum[61:0];
                     phase_in = PH_Q;
                     idx_in   = '0;
                     state_in = ST_START;
                  end
                  default: state_in = ST_SUM;
               endcase
            end else begin
               cnt_in   = cnt_ff + 3'd1;
               state_in = ST_MUL;
            end
         end
         ST_START: begin
            unit_req.start = 1'b1;
            case (phase_ff)
               PH_N1, PH_N2: begin
                  unit_req.is_sqrt = 1'b1;
                  unit_req.operand = acc_ff[63:0];
               end
               PH_U1: begin
                  unit_req.operand = {4'd0, mag32(d1_ff[cnt_ff[1:0]]), 28'd0};
                  unit_req.divisor = {10'd0, n1_ff};
               end
               PH_U2: begin
                  unit_req.operand = {4'd0, mag32(d2_ff[cnt_ff[1:0]]), 28'd0};
                  unit_req.divisor = {10'd0, n2_ff};
               end
               default: begin
                  unit_req.operand = {1'b0, cmag_ff[idx_ff][19:0], 43'd0};
                  unit_req.divisor = s_ff;
               end
            endcase
            state_in = ST_UNIT;
         end
         ST_UNIT: begin
            if (unit_rsp.done) begin
               case (phase_ff)
                  PH_N1: begin
                     n1_in    = n_new;
                     phase_in = PH_N2;
                     cnt_in   = '0;
                     acc_in   = '0;
                     state_in = ST_MUL;
                  end
                  PH_N2: begin
                     n2_in = n_new;
                     if (n1_ff == '0 || n_new == '0 || n1_ff < thr_ff || n_new < thr_ff) begin
                        seg_end = 1'b1;
                     end else begin
                        phase_in = PH_CROSS;
                        cnt_in   = '0;
                        state_in = ST_MUL;
                     end
                  end
                  PH_U1: begin
                     u1_in[cnt_ff[1:0]] = d1_ff[cnt_ff[1:0]][31] ? -$signed(uq) : $signed(uq);
                     if (cnt_ff == 3'd2) begin
                        phase_in = PH_U2;
                        cnt_in   = '0;
                     end else begin
                        cnt_in = cnt_ff + 3'd1;
                     end
                     state_in = ST_START;
                  end
                  PH_U2: begin
                     u2_in[cnt_ff[1:0]] = d2_ff[cnt_ff[1:0]][31] ? -$signed(uq) : $signed(uq);
                     if (cnt_ff == 3'd2) begin
                        phase_in = PH_K;
                        cnt_in   = '0;
                        acc_in   = '0;
                        state_in = ST_MUL;
                     end else begin
                        cnt_in   = cnt_ff + 3'd1;
                        state_in = ST_START;
                     end
                  end
                  default: begin
                     q_in     = unit_rsp.result;
                     phase_in = PH_TERM;
                     cnt_in   = '0;
                     acc_in   = '0;
                     state_in = ST_MUL;
                  end
               endcase
            end
         end
         ST_NORM: begin
            if (|ormag[62:20]) begin
               for (int i = 0; i < 3; i++) cmag_in[i] = cmag_ff[i] >> 1;
               sh_in = sh_ff + 6'd1;
            end else begin
               phase_in = PH_SQ;
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_CHECK: begin
            if (s_skip) begin
               seg_end = 1'b1;
            end else begin
               phase_in = PH_U1;
               cnt_in   = '0;
               state_in = ST_START;
            end
         end
         ST_SUM: begin
            if (phase_ff == PH_TERM) begin
               sum_in[idx_ff] = sum_sat;
               if (idx_ff == 2'd2) begin
                  seg_end = 1'b1;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  phase_in = PH_Q;
                  state_in = ST_START;
               end
            end else begin
               vel_in[idx_ff] = vsat;
               if (idx_ff == 2'd2) begin
                  state_in = ST_OUT;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  cnt_in   = '0;
                  acc_in   = ROUND_HALF;
                  state_in = ST_MUL;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in.vel_x = vel_ff[0];
               rsp_data_in.vel_y = vel_ff[1];
               rsp_data_in.vel_z = vel_ff[2];
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // segment finished or skipped
      if (seg_end) begin
         if (close_ff) begin
            close_in = 1'b0;
            for (int i = 0; i < 3; i++) begin
               a_in[i] = b_ff[i];
               b_in[i] = first_ff[i];
            end
            state_in = ST_DIFF;
         end else if (fin_ff) begin
            fin_in   = 1'b0;
            phase_in = PH_SCALE;
            idx_in   = '0;
            cnt_in   = '0;
            acc_in   = ROUND_HALF;
            state_in = ST_MUL;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_N1;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         in_ring_ff   <= 1'b0;
         close_ff     <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         in_ring_ff   <= in_ring_in;
         close_ff     <= close_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
      end
      rsp_data_ff <= rsp_data_in;
      crneg_ff    <= crneg_in;
      n1_ff       <= n1_in;
      n2_ff       <= n2_in;
      sh_ff       <= sh_in;
      s_ff        <= s_in;
      kneg_ff     <= kneg_in;
      kmag_ff     <= kmag_in;
      q_ff        <= q_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      for (int i = 0; i < 3; i++) begin
         pt_ff[i]    <= pt_in[i];
         first_ff[i] <= first_in[i];
         prev_ff[i]  <= prev_in[i];
         a_ff[i]     <= a_in[i];
         b_ff[i]     <= b_in[i];
         d0_ff[i]    <= d0_in[i];
         d1_ff[i]    <= d1_in[i];
         d2_ff[i]    <= d2_in[i];
         cmag_ff[i]  <= cmag_in[i];
         u1_ff[i]    <= u1_in[i];
         u2_ff[i]    <= u2_in[i];
         sum_ff[i]   <= sum_in[i];
         vel_ff[i]   <= vel_in[i];
      end
   end

   `VRI_ASSERT_IMPLY(a_rsp_from_out, clock, reset, $rose(rsp_valid), $past(state_ff == ST_OUT), "result raised outside output step")
   `VRI_ASSERT_IMPLY(a_start_free, clock, reset, unit_req.start, !unit_rsp.busy, "shared unit started while busy")
   `VRI_ASSERT_NEXT(a_last_closes, clock, reset, req_fire && req_data.ring_last, !in_ring_ff, "ring still open after its last item")
   `VRI_ASSERT_IMPLY(a_close_emits, clock, reset, close_ff, fin_ff, "closing segment pending without a result")

endmodule
